@@ src/ppc_pkg.sv @@
// shared types, constants and helpers of the point projection and cull block
`default_nettype none
package ppc_pkg;

  localparam int COORD_W  = 21;
  localparam int SUB_BITS = 4;
  localparam int VP_W     = 16;
  localparam int COEF_W   = 16;
  localparam int DIST_W   = 44;
  localparam int CAM_W    = 3 * COORD_W;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int SQ_W     = 2 * DIFF_W - 1;
  localparam int PROD_W   = COEF_W + COORD_W;
  localparam int CST_W    = COEF_W + 8;
  localparam int CLIP_W   = PROD_W + 2;
  localparam int NUM_W    = CLIP_W + 1;
  localparam int Q_W      = VP_W + SUB_BITS;
  localparam int DEPTH_W  = 16;
  localparam int QDEPTH   = 4;

  localparam logic signed [CLIP_W-1:0] W_EPS = CLIP_W'(104);
  localparam logic [Q_W-1:0] DEPTH_SCALE = Q_W'(65535);

  localparam logic [1:0] REASON_VISIBLE = 2'd0;
  localparam logic [1:0] REASON_FAR     = 2'd1;
  localparam logic [1:0] REASON_FRUSTUM = 2'd2;
  localparam logic [1:0] REASON_BEHIND  = 2'd3;

  localparam logic [2:0] REG_ROW0 = 3'd0;
  localparam logic [2:0] REG_ROW1 = 3'd1;
  localparam logic [2:0] REG_ROW2 = 3'd2;
  localparam logic [2:0] REG_ROW3 = 3'd3;
  localparam logic [2:0] REG_CAM  = 3'd4;
  localparam logic [2:0] REG_MAXD = 3'd5;
  localparam logic [2:0] REG_VPW  = 3'd6;
  localparam logic [2:0] REG_VPH  = 3'd7;

  typedef struct packed {
    logic [3:0][63:0]   row;
    logic [CAM_W-1:0]   cam;
    logic [DIST_W-1:0]  maxd;
    logic [VP_W-1:0]    vpw;
    logic [VP_W-1:0]    vph;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       reason;
    logic [NUM_W-1:0] num_x;
    logic [NUM_W-1:0] num_y;
    logic [NUM_W-1:0] num_z;
    logic [NUM_W-1:0] twow;
  } q_entry_t;

  typedef struct packed {
    logic [NUM_W-1:0] r;
    logic [Q_W-1:0]   q;
  } div_t;

  // one bit of floor(a*b/c) by long division over the bits of a
  function automatic div_t div_step(input logic [NUM_W-1:0] r, input logic [Q_W-1:0] q,
                                    input logic [NUM_W-1:0] b, input logic [NUM_W-1:0] c,
                                    input logic abit);
    logic [NUM_W:0] t;
    logic [Q_W-1:0] qq;
    div_t res;
    qq = q << 1;
    t = {r, 1'b0};
    if (t >= {1'b0, c}) begin
      t = t - {1'b0, c};
      qq = qq + Q_W'(1);
    end
    if (abit) t = t + {1'b0, b};
    if (t >= {1'b0, c}) begin
      t = t - {1'b0, c};
      qq = qq + Q_W'(1);
    end
    res.r = t[NUM_W-1:0];
    res.q = qq;
    return res;
  endfunction

endpackage
`default_nettype wire

@@ src/point_project_cull_core.sv @@
// Point projection and cull core. Takes one world point per cycle on the in_ stream,
// except while a full queue stalls the front end, and returns one result per point
// on the out_ stream, in order. The front end computes distance, matrix transform
// and cull classification in registered stages, a four-entry queue decouples it from
// the back end, and the back end resolves screen x, y and depth with a twenty-stage
// long-division pipeline, one quotient bit per stage. The sustained rate is one item
// per cycle while the output is not stalled. Registers sit at byte address 8*i on a
// 64-bit port and must be written only while no item is in flight.
`default_nettype none
module point_project_cull_core
  import ppc_pkg::*;
#(
  parameter int QUEUE_DEPTH = QDEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // point_x, point_y, point_z, pad
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // screen_x, screen_y, depth
  output logic [2:0]       out_tuser,  // visible, cull_reason
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [5:0]  cfg_paddr,
  input  wire logic [63:0] cfg_pwdata,
  output logic [63:0]      cfg_prdata,
  output logic             cfg_pready
);

  cfg_t          cfg;
  q_entry_t      qw, qr;
  logic          q_push, q_pop, q_full, q_empty;
  logic          vis;
  logic [1:0]    reason;
  logic [Q_W-1:0] sx, sy;
  logic [DEPTH_W-1:0] dep;

  assign cfg_pready = 1'b1;

  ppc_regs u_regs (
    .clk, .rst_n, .psel(cfg_psel), .penable(cfg_penable), .pwrite(cfg_pwrite),
    .paddr(cfg_paddr), .pwdata(cfg_pwdata), .prdata(cfg_prdata), .cfg(cfg)
  );

  ppc_front u_front (
    .clk, .rst_n, .cfg(cfg), .in_valid(in_tvalid), .in_ready(in_tready),
    .in_pts(in_tdata[CAM_W-1:0]), .q_full(q_full), .q_push(q_push), .q_data(qw)
  );

  ppc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n, .push(q_push), .wdata(qw), .pop(q_pop), .rdata(qr),
    .full(q_full), .empty(q_empty)
  );

  ppc_back u_back (
    .clk, .rst_n, .cfg(cfg), .q_empty(q_empty), .q_data(qr), .q_pop(q_pop),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_visible(vis),
    .out_reason(reason), .out_sx(sx), .out_sy(sy), .out_depth(dep)
  );

  assign out_tdata = {dep, sy, sx};
  assign out_tuser = {reason, vis};

endmodule
`default_nettype wire

@@ src/ppc_regs.sv @@
// configuration register file on the apb-style port
`default_nettype none
module ppc_regs
  import ppc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output cfg_t             cfg
);

  cfg_t       cfg_r;
  logic [2:0] idx;

  assign idx = paddr[5:3];
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row[0] <= 64'd4096;
      cfg_r.row[1] <= 64'd4096 << 16;
      cfg_r.row[2] <= 64'd4096 << 32;
      cfg_r.row[3] <= 64'd4096 << 48;
      cfg_r.cam    <= '0;
      cfg_r.maxd   <= '1;
      cfg_r.vpw    <= VP_W'(1920);
      cfg_r.vph    <= VP_W'(1080);
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_ROW0: cfg_r.row[0] <= pwdata;
        REG_ROW1: cfg_r.row[1] <= pwdata;
        REG_ROW2: cfg_r.row[2] <= pwdata;
        REG_ROW3: cfg_r.row[3] <= pwdata;
        REG_CAM:  cfg_r.cam    <= pwdata[CAM_W-1:0];
        REG_MAXD: cfg_r.maxd   <= pwdata[DIST_W-1:0];
        REG_VPW:  cfg_r.vpw    <= pwdata[VP_W-1:0];
        REG_VPH:  cfg_r.vph    <= pwdata[VP_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ROW0: prdata = cfg_r.row[0];
      REG_ROW1: prdata = cfg_r.row[1];
      REG_ROW2: prdata = cfg_r.row[2];
      REG_ROW3: prdata = cfg_r.row[3];
      REG_CAM:  prdata = 64'(cfg_r.cam);
      REG_MAXD: prdata = 64'(cfg_r.maxd);
      REG_VPW:  prdata = 64'(cfg_r.vpw);
      REG_VPH:  prdata = 64'(cfg_r.vph);
      default:  prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

@@ src/ppc_front.sv @@
// front end: distance, matrix transform and cull classification
`default_nettype none
module ppc_front
  import ppc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  cfg_t                    cfg,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [CAM_W-1:0]   in_pts,
  input  wire logic               q_full,
  output logic                    q_push,
  output q_entry_t                q_data
);

  logic v1_r, v2_r, v3_r;
  logic en;

  logic signed [COORD_W-1:0] p_r [3];
  logic signed [DIFF_W-1:0]  d_r [3];
  logic [SQ_W-1:0]           sq_r [3];
  logic signed [PROD_W-1:0]  prod_r [4][3];
  logic signed [CST_W-1:0]   cst_r [4];
  logic [DIST_W-1:0]         dsq_r;
  logic signed [CLIP_W-1:0]  clip_r [4];

  assign en       = !(v3_r && q_full);
  assign in_ready = en;
  assign q_push   = v3_r && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p_r[i] <= signed'(in_pts[i*COORD_W +: COORD_W]);
        d_r[i] <= DIFF_W'(signed'(in_pts[i*COORD_W +: COORD_W]))
                - DIFF_W'(signed'(cfg.cam[i*COORD_W +: COORD_W]));
      end
    end
  end

  // stage two: squares and matrix products
  always_ff @(posedge clk) begin
    logic signed [SQ_W:0] s;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s = d_r[i] * d_r[i];
        sq_r[i] <= s[SQ_W-1:0];
      end
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++)
          prod_r[r][c] <= signed'(cfg.row[r][c*COEF_W +: COEF_W]) * p_r[c];
        cst_r[r] <= signed'({cfg.row[r][3*COEF_W +: COEF_W], 8'h00});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dsq_r <= DIST_W'(sq_r[0]) + DIST_W'(sq_r[1]) + DIST_W'(sq_r[2]);
      for (int r = 0; r < 4; r++)
        clip_r[r] <= CLIP_W'(prod_r[r][0]) + CLIP_W'(prod_r[r][1])
                   + CLIP_W'(prod_r[r][2]) + CLIP_W'(cst_r[r]);
    end
  end

  always_comb begin
    logic signed [NUM_W-1:0] w, wn, e;
    logic outside;
    w = NUM_W'(clip_r[3]);
    wn = -w;
    outside = 1'b0;
    for (int i = 0; i < 3; i++) begin
      e = NUM_W'(clip_r[i]);
      if (e > w || e < wn) outside = 1'b1;
    end
    if (dsq_r > cfg.maxd)       q_data.reason = REASON_FAR;
    else if (outside)           q_data.reason = REASON_FRUSTUM;
    else if (clip_r[3] <= W_EPS) q_data.reason = REASON_BEHIND;
    else                        q_data.reason = REASON_VISIBLE;
    q_data.num_x = NUM_W'(NUM_W'(clip_r[0]) + w);
    q_data.num_y = NUM_W'(w - NUM_W'(clip_r[1]));
    q_data.num_z = NUM_W'(NUM_W'(clip_r[2]) + w);
    q_data.twow  = {clip_r[3], 1'b0};
  end

endmodule
`default_nettype wire

@@ src/ppc_queue.sv @@
// small queue between the classifying front and the divider back end
`default_nettype none
module ppc_queue
  import ppc_pkg::*;
#(
  parameter int DEPTH = QDEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  q_entry_t  wdata,
  input  wire logic pop,
  output q_entry_t  rdata,
  output logic      full,
  output logic      empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  q_entry_t      mem [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
      if (pop)  rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
      if (push && !pop)      cnt_r <= cnt_r + CW'(1);
      else if (pop && !push) cnt_r <= cnt_r - CW'(1);
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push || pop) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop) else $error("queue pop while empty");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + CW'(1)) else $error("queue count slip");
`endif

endmodule
`default_nettype wire

@@ src/ppc_back.sv @@
// back end: pipelined long division to screen coordinates and depth
`default_nettype none
module ppc_back
  import ppc_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  cfg_t                cfg,
  input  wire logic           q_empty,
  input  q_entry_t            q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic                out_visible,
  output logic [1:0]          out_reason,
  output logic [Q_W-1:0]      out_sx,
  output logic [Q_W-1:0]      out_sy,
  output logic [DEPTH_W-1:0]  out_depth
);

  localparam int STAGES = Q_W;

  typedef struct packed {
    q_entry_t e;
    div_t     dx;
    div_t     dy;
    div_t     dz;
  } bstage_t;

  logic     vld_r [STAGES];
  bstage_t  st_r  [STAGES];
  bstage_t  st_in [STAGES];
  logic     en;
  logic [Q_W-1:0] ax, ay;
  logic     vis;

  assign ax    = {cfg.vpw, SUB_BITS'(0)};
  assign ay    = {cfg.vph, SUB_BITS'(0)};
  assign en    = !vld_r[STAGES-1] || out_ready;
  assign q_pop = en && !q_empty;

  always_comb begin
    st_in[0].e  = q_data;
    st_in[0].dx = '0;
    st_in[0].dy = '0;
    st_in[0].dz = '0;
    for (int k = 1; k < STAGES; k++) st_in[k] = st_r[k-1];
  end

  // stage k takes bit STAGES-1-k of each scale factor
  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[k] <= 1'b0;
      else if (en) vld_r[k] <= (k == 0) ? !q_empty : vld_r[(k == 0) ? 0 : k-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k].e  <= st_in[k].e;
        st_r[k].dx <= div_step(st_in[k].dx.r, st_in[k].dx.q, st_in[k].e.num_x,
                               st_in[k].e.twow, ax[STAGES-1-k]);
        st_r[k].dy <= div_step(st_in[k].dy.r, st_in[k].dy.q, st_in[k].e.num_y,
                               st_in[k].e.twow, ay[STAGES-1-k]);
        st_r[k].dz <= div_step(st_in[k].dz.r, st_in[k].dz.q, st_in[k].e.num_z,
                               st_in[k].e.twow, DEPTH_SCALE[STAGES-1-k]);
      end
    end
  end

  assign vis         = (st_r[STAGES-1].e.reason == REASON_VISIBLE);
  assign out_valid   = vld_r[STAGES-1];
  assign out_visible = vis;
  assign out_reason  = st_r[STAGES-1].e.reason;
  assign out_sx      = vis ? st_r[STAGES-1].dx.q : '0;
  assign out_sy      = vis ? st_r[STAGES-1].dy.q : '0;
  assign out_depth   = vis ? st_r[STAGES-1].dz.q[DEPTH_W-1:0] : '0;

`ifndef ASSERT_OFF
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_reason))
    else $error("result dropped under stall");
  a_culled_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_visible |-> out_sx == '0 && out_sy == '0 && out_depth == '0)
    else $error("culled item carries coordinates");
  a_pop_flow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> vld_r[0]) else $error("popped item lost");
`endif

endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
// self-checking testbench of the point projection and cull core
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ppc_pkg::*;

  typedef struct packed {
    logic        visible;
    logic [1:0]  reason;
    logic [19:0] sx;
    logic [19:0] sy;
    logic [15:0] depth;
  } proj_t;

  typedef struct {
    logic [20:0] px;
    logic [20:0] py;
    logic [20:0] pz;
    bit          known;
    proj_t       res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  wire         in_tready;
  logic [63:0] in_tdata = '0;
  wire         out_tvalid;
  logic        out_tready = 1'b0;
  wire  [55:0] out_tdata;
  wire  [2:0]  out_tuser;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [5:0]  cfg_paddr = '0;
  logic [63:0] cfg_pwdata = '0;
  wire  [63:0] cfg_prdata;
  wire         cfg_pready;

  point_project_cull_core dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow copy of the registers
  logic [63:0] m_row [4];
  logic [62:0] m_cam;
  logic [43:0] m_maxd;
  logic [15:0] m_vw, m_vh;

  proj_t  pending_proj [$];
  int     n_errors = 0;
  int     busy_left = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  function automatic logic [63:0] scaled_div(input logic [63:0] a, input logic [63:0] b,
                                              input logic [63:0] c);
    logic [127:0] prod;
    prod = a * b;
    return 64'(prod / c);
  endfunction

  function automatic proj_t project_point(input logic [20:0] px, input logic [20:0] py,
                                          input logic [20:0] pz);
    proj_t r;
    longint p [3];
    longint clip [4];
    logic [63:0] dsq, sq, mag, twow;
    longint d;
    logic [20:0] camf;
    r = '{1'b0, REASON_VISIBLE, 20'd0, 20'd0, 16'd0};
    p[0] = longint'(signed'(px));
    p[1] = longint'(signed'(py));
    p[2] = longint'(signed'(pz));
    dsq = 0;
    for (int i = 0; i < 3; i++) begin
      camf = m_cam[i*21 +: 21];
      d = p[i] - longint'(signed'(camf));
      mag = (d < 0) ? 64'(-d) : 64'(d);
      sq = (mag > 64'hFFFF_FFFF) ? '1 : mag * mag;
      dsq = (dsq + sq < dsq) ? '1 : dsq + sq;
    end
    if (dsq > 64'(m_maxd)) begin
      r.reason = REASON_FAR;
      return r;
    end
    for (int i = 0; i < 4; i++) begin
      clip[i] = longint'(signed'(m_row[i][63:48])) * 256;
      for (int j = 0; j < 3; j++)
        clip[i] += longint'(signed'(m_row[i][16*j +: 16])) * p[j];
    end
    for (int i = 0; i < 3; i++)
      if (clip[i] > clip[3] || clip[i] < -clip[3]) begin
        r.reason = REASON_FRUSTUM;
        return r;
      end
    if (clip[3] <= 104) begin
      r.reason = REASON_BEHIND;
      return r;
    end
    twow = 64'(2 * clip[3]);
    r.visible = 1'b1;
    r.sx = 20'(scaled_div(64'(m_vw) << SUB_BITS, 64'(clip[0] + clip[3]), twow));
    r.sy = 20'(scaled_div(64'(m_vh) << SUB_BITS, 64'(clip[3] - clip[1]), twow));
    r.depth = 16'(scaled_div(64'd65535, 64'(clip[2] + clip[3]), twow));
    return r;
  endfunction

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 2) == 0) n = 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 3'b000};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_ROW0, REG_ROW1, REG_ROW2, REG_ROW3: m_row[idx] = val;
      REG_CAM:  m_cam = val[62:0];
      REG_MAXD: m_maxd = val[43:0];
      REG_VPW:  m_vw = val[15:0];
      default:  m_vh = val[15:0];
    endcase
  endtask

  // one point item, expectation queued at acceptance
  task automatic send_point(input logic [20:0] px, input logic [20:0] py,
                            input logic [20:0] pz, input bit known, input proj_t want);
    proj_t pred;
    pred = project_point(px, py, pz);
    if (known && pred != want) report("table row", 64'(pred), 64'(want));
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, pz, py, px};
    do @(posedge clk); while (!in_tready);
    pending_proj.push_back(pred);
    if ($urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      idle_gap();
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_proj.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [20:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return 21'($signed($urandom_range(0, 2048)) - 1024);
      1: return 21'($signed($urandom_range(0, 65536)) - 32768);
      default: return 21'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_coef();
    case ($urandom_range(0, 3))
      0: return 16'($signed($urandom_range(0, 8192)) - 4096);
      1: return 16'($urandom_range(0, 1) ? 4096 : -4096);
      default: return 16'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    proj_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_proj.size() == 0) begin
        report("unexpected item", {out_tuser, out_tdata}, '0);
      end else begin
        want = pending_proj.pop_front();
        if (out_tuser[0] !== want.visible) report("visible", out_tuser[0], want.visible);
        if (out_tuser[2:1] !== want.reason) report("cull_reason", out_tuser[2:1], want.reason);
        if (out_tdata[19:0] !== want.sx) report("screen_x", out_tdata[19:0], want.sx);
        if (out_tdata[39:20] !== want.sy) report("screen_y", out_tdata[39:20], want.sy);
        if (out_tdata[55:40] !== want.depth) report("depth", out_tdata[55:40], want.depth);
      end
    end
    // occasional long back pressure, otherwise short random stalls
    if (busy_left > 0) begin
      busy_left--;
      out_tready <= 1'b0;
    end else if (rst_n && $urandom_range(0, 60) == 0) begin
      busy_left = $urandom_range(5, 40);
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 9) != 0) || !rst_n;
    end
  end

  localparam proj_t NO_PROJ = '{1'b0, REASON_VISIBLE, 20'd0, 20'd0, 16'd0};
  stim_row_t directed [] = '{
    '{21'd0, 21'd0, 21'd0, 1'b0, NO_PROJ},
    '{21'd256, 21'd0, 21'd0, 1'b0, NO_PROJ},
    '{21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF, 1'b1, '{1'b0, REASON_FRUSTUM, 20'd0, 20'd0, 16'd0}},
    '{21'h100000, 21'h100000, 21'h100000, 1'b1, '{1'b0, REASON_FRUSTUM, 20'd0, 20'd0, 16'd0}},
    '{21'h0FFFFF, 21'h100000, 21'h0, 1'b0, NO_PROJ},
    '{21'd100, 21'h1FFF9C, 21'd50, 1'b0, NO_PROJ},
    '{21'd128, 21'd128, 21'd128, 1'b0, NO_PROJ},
    '{21'h1FFF00, 21'd256, 21'h1FFF80, 1'b0, NO_PROJ},
    '{21'h155555, 21'h0AAAAA, 21'h155555, 1'b0, NO_PROJ},
    '{21'h0AAAAA, 21'h155555, 21'h0AAAAA, 1'b0, NO_PROJ}
  };

  initial begin
    int phase_items;
    m_row[0] = 64'd4096;
    m_row[1] = 64'd4096 << 16;
    m_row[2] = 64'd4096 << 32;
    m_row[3] = 64'd4096 << 48;
    m_cam = '0;
    m_maxd = '1;
    m_vw = 16'd1920;
    m_vh = 16'd1080;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity with w term of 1.0: near points project
    foreach (directed[k])
      send_point(directed[k].px, directed[k].py, directed[k].pz, directed[k].known,
                 directed[k].res);
    drain();
    // w column = 1.0, far limit small, then extremes
    write_reg(REG_ROW3, 64'h1000_0000_0000_0000);
    write_reg(REG_MAXD, 44'd0);
    send_point(21'd0, 21'd0, 21'd0, 1'b0, NO_PROJ);
    send_point(21'd1, 21'd0, 21'd0, 1'b1, '{1'b0, REASON_FAR, 20'd0, 20'd0, 16'd0});
    drain();
    write_reg(REG_MAXD, '1);
    write_reg(REG_VPW, 16'hFFFF);
    write_reg(REG_VPH, 16'd0);
    write_reg(REG_CAM, 63'h7FFF_FFFF_FFFF_FFFF);
    send_point(21'd100, 21'd100, 21'd100, 1'b0, NO_PROJ);
    send_point(21'h1FFF9C, 21'h1FFF9C, 21'd255, 1'b0, NO_PROJ);
    send_point(21'h100000, 21'h100000, 21'h100000, 1'b0, NO_PROJ);
    drain();
    // w at zero: behind camera at the clip origin
    write_reg(REG_ROW3, 64'd0);
    send_point(21'd0, 21'd0, 21'd0, 1'b1, '{1'b0, REASON_BEHIND, 20'd0, 20'd0, 16'd0});
    drain();
    write_reg(REG_ROW3, 64'hFFFF_0000_0000_0000);
    send_point(21'd0, 21'd0, 21'd0, 1'b0, NO_PROJ);
    drain();
    write_reg(REG_ROW0, '0);
    write_reg(REG_ROW1, '0);
    write_reg(REG_ROW2, '0);
    send_point(21'd5, 21'd7, 21'd9, 1'b0, NO_PROJ);
    drain();

    // random phases with random registers
    for (int ph = 0; ph < 8; ph++) begin
      for (int r = 0; r < 4; r++)
        write_reg(3'(r), {rand_coef(), rand_coef(), rand_coef(), rand_coef()});
      if (ph % 2 == 0) write_reg(REG_ROW3, {16'd4096, rand_coef() >>> 6, 16'd0, 16'd0});
      write_reg(REG_CAM, {$urandom_range(0, 3) == 0 ? 63'($urandom) : 63'd0} ^
                         ($urandom_range(0, 1) ? 63'({$urandom, $urandom}) : 63'd0));
      write_reg(REG_MAXD, ph == 7 ? 44'd0 : ($urandom_range(0, 1) ? '1 : 44'({$urandom, $urandom})));
      write_reg(REG_VPW, ph == 3 ? 16'hFFFF : 16'($urandom_range(1, 65535)));
      write_reg(REG_VPH, ph == 3 ? 16'd1 : 16'($urandom));
      phase_items = 50;
      for (int k = 0; k < phase_items; k++)
        send_point(rand_coord(), rand_coord(), rand_coord(), 1'b0, NO_PROJ);
      drain();
    end

    if (n_errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
`default_nettype wire
